// ===== src/cbs_pkg.sv =====
package cbs_pkg;

  localparam int MAX_POINTS = 64;
  localparam int MAX_ORDER  = 8;

  // Field widths fixed by the interface.
  localparam int LP_W    = 6;
  localparam int ORD_W   = 4;
  localparam int NS_W    = 16;
  localparam int COORD_W = 24;
  localparam int FRAC    = 16;

  // Derived widths.
  localparam int PT_W    = $clog2(MAX_POINTS);
  localparam int L       = 2 * MAX_ORDER;
  localparam int M_W     = $clog2(L);
  localparam int KNOT_W  = LP_W + 1;
  localparam int J_W     = LP_W + M_W + 2;
  localparam int V_W     = KNOT_W + FRAC;
  localparam int AB_W    = V_W + 1;
  localparam int BAS_W   = FRAC + 2;
  localparam int MA_W    = COORD_W + 1;
  localparam int MB_W    = BAS_W + 1;
  localparam int P_W     = MA_W + MB_W;
  localparam int DIV_W   = 42;
  localparam int DEN_W   = NS_W;
  localparam int DIV_STEP = 6;
  localparam int DIV_CYC  = DIV_W / DIV_STEP;
  localparam int DC_W    = $clog2(DIV_CYC);
  localparam int TACC_W  = DIV_W + 1;
  localparam int ACC_W   = P_W + M_W;
  localparam int RAM_W   = 2 * COORD_W;

  typedef struct packed {
    logic                      mode;
    logic [5:0]                point_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [15:0]               sample_index;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic [15:0]               out_index;
    logic                      bad_setup;
  } out_t;

  typedef enum logic [1:0] {
    REG_LAST_POINT  = 2'd0,
    REG_ORDER       = 2'd1,
    REG_NUM_SAMPLES = 2'd2
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LAST, S_VMUL, S_DIV, S_INIT, S_CELL, S_TERM, S_MUL, S_CELLEND,
    S_MREAD, S_MWAIT, S_MX, S_MY, S_MACC, S_ROUND, S_DONE
  } state_t;

  // Integer clamped knot vector.
  function automatic logic [KNOT_W-1:0] knot_at(input logic [J_W-1:0] j,
                                                input logic [LP_W-1:0] n,
                                                input logic [ORD_W-1:0] t);
    logic [J_W-1:0] nn;
    logic [J_W-1:0] tt;
    nn = J_W'(n);
    tt = J_W'(t);
    if (j < tt) knot_at = '0;
    else if (j <= nn) knot_at = KNOT_W'(j - tt + J_W'(1));
    else knot_at = KNOT_W'(nn - tt + J_W'(2));
  endfunction

endpackage

// ===== src/cbs_ram.sv =====
module cbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== src/clamped_bspline_curve_eval.sv =====
// Load items are taken whenever the block is idle and do not make it busy. An evaluate
// item keeps it busy until its result is loaded: a bad set-up goes straight to output,
// the final sample reads the last control point, and other samples run Cox-de Boor cells
// over L = 16 basis slots on the one shared multiplier and the 6-bit-per-cycle divider.
// Synchronous active-high reset clears the registers to 3, 4 and 64 and idles the block;
// the control point store holds no reset value.
module clamped_bspline_curve_eval
  import cbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [BAS_W-1:0] Q_ONE = BAS_W'(1) << FRAC;
  localparam logic [TACC_W-1:0] T_HALF = TACC_W'(1) << (FRAC - 1);
  localparam logic signed [ACC_W-1:0] A_HALF = ACC_W'(1) << (FRAC - 1);

  // Configuration registers.
  logic [LP_W-1:0]  last_point;
  logic [ORD_W-1:0] order;
  logic [NS_W-1:0]  num_samples;

  state_t state, state_next;

  logic [NS_W-1:0]         sidx;
  logic [V_W-1:0]          v;
  logic [M_W-1:0]          m;
  logic [M_W-1:0]          cnt;
  logic [ORD_W-1:0]        r;
  logic                    term;
  logic                    div_v;
  logic [DIV_W-1:0]        div_num;
  logic [DEN_W-1:0]        div_rem;
  logic [DEN_W-1:0]        div_den;
  logic [DC_W-1:0]         div_cnt;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [P_W-1:0]   prod;
  logic [TACC_W-1:0]       tacc;
  logic [BAS_W-1:0]        basis [L];
  logic signed [ACC_W-1:0] sx;
  logic signed [ACC_W-1:0] sy;
  logic signed [COORD_W-1:0] ytmp;
  logic                    k_ok;
  logic                    last_ok;
  logic signed [COORD_W-1:0] res_x;
  logic signed [COORD_W-1:0] res_y;
  logic                    res_bad;

  // RAM.
  logic             ram_we;
  logic [PT_W-1:0]  ram_raddr;
  logic [RAM_W-1:0] ram_rdata;

  cbs_ram #(.WIDTH(RAM_W), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (PT_W'(in_data.point_index)),
    .wdata ({in_data.coord_x, in_data.coord_y}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic signed [COORD_W-1:0] rd_x, rd_y;
  assign rd_x = ram_rdata[RAM_W-1:COORD_W];
  assign rd_y = ram_rdata[COORD_W-1:0];

  // APB port.
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_LAST_POINT:  prdata = 32'(last_point);
      REG_ORDER:       prdata = 32'(order);
      REG_NUM_SAMPLES: prdata = 32'(num_samples);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_point  <= LP_W'(3);
      order       <= ORD_W'(4);
      num_samples <= NS_W'(64);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LAST_POINT:  last_point  <= pwdata[LP_W-1:0];
        REG_ORDER:       order       <= pwdata[ORD_W-1:0];
        REG_NUM_SAMPLES: num_samples <= pwdata[NS_W-1:0];
        default: ;
      endcase
    end
  end

  // Set-up checks on the live registers.
  logic            bad_cfg;
  logic            final_sample;
  logic [KNOT_W-1:0] span;
  logic            accept_eval;

  assign bad_cfg = (order == '0) || (32'(order) > MAX_ORDER) ||
                   ((KNOT_W'(last_point) + KNOT_W'(2)) <= KNOT_W'(order));
  assign final_sample = (num_samples < NS_W'(2)) ||
                        (in_data.sample_index >= (num_samples - NS_W'(1)));
  assign span = KNOT_W'(last_point) + KNOT_W'(2) - KNOT_W'(order);
  assign accept_eval = in_valid && in_ready && in_data.mode;

  // Knots of the current cell.
  logic [J_W-1:0]    j0;
  logic [KNOT_W-1:0] kj, kj1, kjr1, kjr, d1, d2;
  logic [V_W-1:0]    kjq, kj1q, kjrq;
  logic signed [AB_W-1:0] a_dist, b_dist;
  logic              en1, en2, init_hit;
  logic [LP_W-1:0]   s;

  assign s    = v[FRAC +: LP_W];
  assign j0   = J_W'(s) + J_W'(m);
  assign kj   = knot_at(j0, last_point, order);
  assign kj1  = knot_at(j0 + J_W'(1), last_point, order);
  assign kjr1 = knot_at(j0 + J_W'(r) - J_W'(1), last_point, order);
  assign kjr  = knot_at(j0 + J_W'(r), last_point, order);
  assign d1   = kjr1 - kj;
  assign d2   = kjr - kj1;
  assign kjq  = {kj, FRAC'(0)};
  assign kj1q = {kj1, FRAC'(0)};
  assign kjrq = {kjr, FRAC'(0)};
  assign a_dist = $signed({1'b0, v}) - $signed({1'b0, kjq});
  assign b_dist = $signed({1'b0, kjrq}) - $signed({1'b0, v});
  assign en1 = (d1 != '0) && (basis[0] != '0) && (a_dist > 0);
  assign en2 = (d2 != '0) && (basis[1] != '0) && (b_dist > 0);
  assign init_hit = (m < cnt) && (kjq <= v) && (v < kj1q);

  // Shared multiplier.
  logic signed [P_W-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // Divider: six quotient bits a cycle.
  logic [DEN_W:0]   dv_rm;
  logic [DIV_W-1:0] dv_q;
  always_comb begin
    dv_rm = {1'b0, div_rem};
    dv_q  = div_num;
    for (int i = 0; i < DIV_STEP; i++) begin
      dv_rm = {dv_rm[DEN_W-1:0], dv_q[DIV_W-1]};
      dv_q  = {dv_q[DIV_W-2:0], 1'b0};
      if (dv_rm >= {1'b0, div_den}) begin
        dv_rm = dv_rm - {1'b0, div_den};
        dv_q[0] = 1'b1;
      end
    end
  end

  logic div_done, row_last, mac_last;
  assign div_done = (div_cnt == DC_W'(DIV_CYC - 1));
  assign row_last = (m == M_W'(L - 1));
  assign mac_last = (M_W'(m) == M_W'(order - ORD_W'(1)));

  logic [J_W-1:0] k_idx;
  assign k_idx = J_W'(s) + J_W'(m);

  logic [TACC_W-1:0] tacc_rnd;
  assign tacc_rnd = tacc + T_HALF;

  function automatic logic signed [COORD_W-1:0] to_coord(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-FRAC-1:0] q;
    t = acc + A_HALF;
    q = t[ACC_W-1:FRAC];
    if (q > $signed((ACC_W-FRAC)'(8388607))) to_coord = 24'sh7FFFFF;
    else if (q < -$signed((ACC_W-FRAC)'(8388608))) to_coord = 24'sh800000;
    else to_coord = q[COORD_W-1:0];
  endfunction

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept_eval) begin
          if (bad_cfg) state_next = S_DONE;
          else if (final_sample) state_next = S_LAST;
          else state_next = S_VMUL;
        end
      end
      S_LAST:  state_next = S_DONE;
      S_VMUL:  state_next = S_DIV;
      S_DIV: begin
        if (div_done) begin
          if (div_v) state_next = S_INIT;
          else if (!term) state_next = S_TERM;
          else state_next = S_CELLEND;
        end
      end
      S_INIT: begin
        if (row_last) state_next = (order == ORD_W'(1)) ? S_MREAD : S_CELL;
      end
      S_CELL: begin
        if (m < cnt) state_next = S_TERM;
        else if (row_last && r == order) state_next = S_MREAD;
      end
      S_TERM: begin
        if (term ? en2 : en1) state_next = S_MUL;
        else if (term) state_next = S_CELLEND;
      end
      S_MUL:   state_next = S_DIV;
      S_CELLEND: state_next = (row_last && r == order) ? S_MREAD : S_CELL;
      S_MREAD: state_next = S_MWAIT;
      S_MWAIT: state_next = S_MX;
      S_MX:    state_next = S_MY;
      S_MY:    state_next = S_MACC;
      S_MACC:  state_next = mac_last ? S_ROUND : S_MREAD;
      S_ROUND: state_next = S_DONE;
      S_DONE:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready  = (state == S_IDLE);
    ram_we    = in_valid && (state == S_IDLE) && !in_data.mode &&
                (32'(in_data.point_index) < MAX_POINTS);
    ram_raddr = (state == S_IDLE) ? PT_W'(last_point) : PT_W'(k_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        sidx    <= in_data.sample_index;
        res_x   <= '0;
        res_y   <= '0;
        res_bad <= bad_cfg;
        last_ok <= (32'(last_point) < MAX_POINTS);
        mul_a   <= MA_W'(in_data.sample_index);
        mul_b   <= MB_W'(span);
      end
      S_LAST: begin
        res_x <= last_ok ? rd_x : '0;
        res_y <= last_ok ? rd_y : '0;
      end
      S_VMUL: begin
        div_num <= DIV_W'(mul_p) << FRAC;
        div_rem <= '0;
        div_cnt <= '0;
        div_den <= num_samples - NS_W'(1);
        div_v   <= 1'b1;
      end
      S_DIV: begin
        div_num <= dv_q;
        div_rem <= dv_rm[DEN_W-1:0];
        div_cnt <= div_cnt + DC_W'(1);
        if (div_done) begin
          if (div_v) begin
            v   <= dv_q[V_W-1:0];
            m   <= '0;
            cnt <= M_W'(2 * order - 1);
          end else begin
            tacc <= tacc + TACC_W'(dv_q);
            term <= 1'b1;
          end
        end
      end
      S_INIT: begin
        for (int i = 0; i < L - 1; i++) basis[i] <= basis[i+1];
        basis[L-1] <= init_hit ? Q_ONE : '0;
        // Each row walk, and the blend after it, starts at slot zero.
        m <= row_last ? '0 : m + M_W'(1);
        if (row_last) begin
          r   <= ORD_W'(2);
          cnt <= cnt - M_W'(1);
          sx  <= '0;
          sy  <= '0;
        end
      end
      S_CELL: begin
        term <= 1'b0;
        tacc <= '0;
        if (!(m < cnt)) begin
          // Slot past the end of the row: rotate so the new row ends up in front.
          for (int i = 0; i < L - 1; i++) basis[i] <= basis[i+1];
          basis[L-1] <= basis[0];
          m <= row_last ? '0 : m + M_W'(1);
          if (row_last) begin
            r   <= r + ORD_W'(1);
            cnt <= cnt - M_W'(1);
          end
        end
      end
      S_TERM: begin
        if (term ? en2 : en1) begin
          mul_a   <= term ? MA_W'(b_dist) : MA_W'(a_dist);
          mul_b   <= term ? MB_W'(basis[1]) : MB_W'(basis[0]);
          div_den <= term ? DEN_W'(d2) : DEN_W'(d1);
        end else begin
          term <= 1'b1;
        end
      end
      S_MUL: begin
        div_num <= mul_p[DIV_W-1:0];
        div_rem <= '0;
        div_cnt <= '0;
        div_v   <= 1'b0;
      end
      S_CELLEND: begin
        for (int i = 0; i < L - 1; i++) basis[i] <= basis[i+1];
        basis[L-1] <= tacc_rnd[FRAC +: BAS_W];
        m <= row_last ? '0 : m + M_W'(1);
        if (row_last) begin
          r   <= r + ORD_W'(1);
          cnt <= cnt - M_W'(1);
        end
      end
      S_MREAD: begin
        k_ok <= (32'(k_idx) < MAX_POINTS);
      end
      S_MWAIT: begin
        mul_a <= k_ok ? MA_W'(rd_x) : '0;
        ytmp  <= k_ok ? rd_y : '0;
        mul_b <= MB_W'(basis[0]);
      end
      S_MX: begin
        prod  <= mul_p;
        mul_a <= MA_W'(ytmp);
      end
      S_MY: begin
        sx   <= sx + ACC_W'(prod);
        prod <= mul_p;
      end
      S_MACC: begin
        sy <= sy + ACC_W'(prod);
        for (int i = 0; i < L - 1; i++) basis[i] <= basis[i+1];
        basis[L-1] <= basis[0];
        m <= m + M_W'(1);
      end
      S_ROUND: begin
        res_x   <= to_coord(sx);
        res_y   <= to_coord(sy);
        res_bad <= 1'b0;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_data.out_x     <= res_x;
      out_data.out_y     <= res_y;
      out_data.out_index <= sidx;
      out_data.bad_setup <= res_bad;
    end
  end

`ifndef ASSERT_OFF
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    accept_eval |=> !in_ready)
    else $error("evaluate item did not make the block busy");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_den != '0))
    else $error("divider started with a zero divisor");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CELL) |-> (r >= ORD_W'(2) && r <= order))
    else $error("Cox-de Boor row count out of range");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=> out_valid)
    else $error("finished item not presented");
`endif

endmodule
